// File: rtl/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg
// Shared constants, request and status codes, and the controller/datapath
// command and status structs of the sorted multiset table.
// ----------------------------------------------------------------------------
`default_nettype none

package smt_pkg;

    localparam int CAPACITY    = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int VAL_W       = 32;
    localparam int REQ_W       = 2;
    localparam int STS_W       = 2;
    localparam int CNT_OUT_W   = 16;
    localparam int USED_OUT_W  = 5;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int USED_W      = $clog2(CAPACITY + 1);
    localparam int ENT_W       = VAL_W + COUNT_WIDTH;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RMMAX  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    // result status codes
    localparam logic [STS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic load;
        logic dispatch;
        logic max_fin;
        logic srch;
        logic decide;
        logic shift;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic go_search;
        logic go_max;
        logic srch_done;
        logic need_shift;
        logic shift_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/smt_req_if.sv
// ----------------------------------------------------------------------------
// smt_req_if
// Request channel: valid/ready handshake with request type and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface smt_req_if;
    logic                               valid;
    logic                               ready;
    logic        [smt_pkg::REQ_W-1:0]   req_type;
    logic signed [smt_pkg::VAL_W-1:0]   value;

    modport source(output valid, output req_type, output value, input ready);
    modport sink(input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/smt_rsp_if.sv
// ----------------------------------------------------------------------------
// smt_rsp_if
// Response channel: valid/ready handshake with status, value, count, fill.
// ----------------------------------------------------------------------------
`default_nettype none

interface smt_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic        [smt_pkg::STS_W-1:0]       status;
    logic signed [smt_pkg::VAL_W-1:0]       result_value;
    logic        [smt_pkg::CNT_OUT_W-1:0]   value_count;
    logic        [smt_pkg::USED_OUT_W-1:0]  entries_used;

    modport source(output valid, output status, output result_value,
                   output value_count, output entries_used, input ready);
    modport sink(input valid, input status, input result_value,
                 input value_count, input entries_used, output ready);
endinterface

`default_nettype wire

// File: rtl/smt_ram.sv
// ----------------------------------------------------------------------------
// smt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/smt_ctrl.sv
// ----------------------------------------------------------------------------
// smt_ctrl
// Request sequencer: dispatch, ordered search, decision, entry shift and
// result hand-off, driving the datapath by command bits.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output      logic             o_in_ready,
    input  wire smt_pkg::t_dp_sts i_sts,
    output      smt_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_MAXD  = 3'd2;
    localparam logic [2:0] S_SRCH  = 3'd3;
    localparam logic [2:0] S_DEC   = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.dispatch = 1'b1;
                priority if (i_sts.go_search) begin
                    n_state = S_SRCH;
                end else if (i_sts.go_max) begin
                    n_state = S_MAXD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MAXD: begin
                o_cmd.max_fin = 1'b1;
                n_state       = S_FIN;
            end
            S_SRCH: begin
                o_cmd.srch = 1'b1;
                if (i_sts.srch_done) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.need_shift ? S_SHIFT : S_FIN;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/smt_dp.sv
// ----------------------------------------------------------------------------
// smt_dp
// Datapath: entry memory, request registers, fill count, search and shift
// pointers, and the output register of the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire smt_pkg::t_dp_cmd                    i_cmd,
    output      smt_pkg::t_dp_sts                    o_sts,
    input  wire logic        [smt_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic signed [smt_pkg::VAL_W-1:0]    i_value,
    output      logic                                o_out_valid,
    input  wire logic                                i_out_ready,
    output      logic        [smt_pkg::STS_W-1:0]    o_status,
    output      logic signed [smt_pkg::VAL_W-1:0]    o_result_value,
    output      logic        [smt_pkg::CNT_OUT_W-1:0] o_value_count,
    output      logic        [smt_pkg::USED_OUT_W-1:0] o_entries_used
);

    localparam int CW = smt_pkg::COUNT_WIDTH;
    localparam int VW = smt_pkg::VAL_W;
    localparam int UW = smt_pkg::USED_W;
    localparam int IW = smt_pkg::IDX_W;
    localparam int EW = smt_pkg::ENT_W;

    // request and table control
    logic        [smt_pkg::REQ_W-1:0] r_req, n_req;
    logic signed [VW-1:0]             r_val, n_val;
    logic        [UW-1:0]             r_used, n_used;
    // read pointer, data tag and remaining moves
    logic        [UW-1:0]             r_ra, n_ra;
    logic                             r_dv, n_dv;
    logic        [UW-1:0]             r_di, n_di;
    logic        [UW-1:0]             r_rem, n_rem;
    logic                             r_up, n_up;
    // search outcome
    logic        [UW-1:0]             r_pos, n_pos;
    logic                             r_found, n_found;
    logic        [CW-1:0]             r_cnt, n_cnt;
    // pending result
    logic        [smt_pkg::STS_W-1:0] r_st, n_st;
    logic signed [VW-1:0]             r_rv, n_rv;
    logic        [CW-1:0]             r_rc, n_rc;
    // output register
    logic                             r_ovalid, n_ovalid;
    logic        [smt_pkg::STS_W-1:0] r_ost, n_ost;
    logic signed [VW-1:0]             r_orv, n_orv;
    logic        [CW-1:0]             r_orc, n_orc;
    logic        [UW-1:0]             r_oused, n_oused;

    // memory ports
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [IW-1:0] w_raddr;
    logic [EW-1:0] w_rdata;

    logic signed [VW-1:0] w_rd_val;
    logic        [CW-1:0] w_rd_cnt;
    logic                 w_used0;
    logic                 w_full;
    logic        [CW-1:0] w_cnt_inc;
    logic                 w_hit;
    logic                 w_exhaust;
    logic        [UW-1:0] w_used_m1;
    logic        [UW-1:0] w_sh_addr;

    smt_ram #(
        .WIDTH (EW),
        .DEPTH (smt_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_val  = w_rdata[EW-1 -: VW];
    assign w_rd_cnt  = w_rdata[CW-1:0];
    assign w_used0   = (r_used == '0);
    assign w_full    = (r_used == UW'(smt_pkg::CAPACITY));
    assign w_used_m1 = r_used - UW'(1);
    // saturating increment
    assign w_cnt_inc = (r_cnt == {CW{1'b1}}) ? r_cnt : r_cnt + CW'(1);
    // first entry not below the value ends the scan
    assign w_hit     = r_dv && (w_rd_val >= r_val);
    assign w_exhaust = !r_dv && (r_ra >= r_used);
    assign w_sh_addr = r_up ? (r_di - UW'(1)) : (r_di + UW'(1));
    assign w_raddr   = i_cmd.dispatch ? w_used_m1[IW-1:0] : r_ra[IW-1:0];

    always_comb begin
        o_sts.go_search  = (r_req == smt_pkg::REQ_INSERT) ||
                           ((r_req == smt_pkg::REQ_DELETE) && !w_used0);
        o_sts.go_max     = (r_req == smt_pkg::REQ_RMMAX) && !w_used0;
        o_sts.srch_done  = w_hit || w_exhaust;
        o_sts.need_shift = (r_req == smt_pkg::REQ_INSERT) ? (!r_found && !w_full)
                                                           : (r_found && !(r_cnt > CW'(1)));
        o_sts.shift_done = !r_dv && (r_rem == '0);
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

    always_comb begin
        n_req    = r_req;
        n_val    = r_val;
        n_used   = r_used;
        n_ra     = r_ra;
        n_dv     = r_dv;
        n_di     = r_di;
        n_rem    = r_rem;
        n_up     = r_up;
        n_pos    = r_pos;
        n_found  = r_found;
        n_cnt    = r_cnt;
        n_st     = r_st;
        n_rv     = r_rv;
        n_rc     = r_rc;
        n_ovalid = r_ovalid;
        n_ost    = r_ost;
        n_orv    = r_orv;
        n_orc    = r_orc;
        n_oused  = r_oused;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = '0;

        if (i_cmd.load) begin
            n_req = i_req_type;
            n_val = i_value;
        end

        if (i_cmd.dispatch) begin
            n_ra = '0;
            n_dv = 1'b0;
            if (!o_sts.go_search && !o_sts.go_max) begin
                n_rc = '0;
                n_rv = '0;
                if (r_req == smt_pkg::REQ_CLEAR) begin
                    n_st   = w_used0 ? smt_pkg::ST_EMPTY : smt_pkg::ST_DONE;
                    n_used = '0;
                end else begin
                    n_st = smt_pkg::ST_EMPTY;
                    if (r_req == smt_pkg::REQ_DELETE) begin
                        n_rv = r_val;
                    end
                end
            end
        end

        if (i_cmd.max_fin) begin
            n_st   = smt_pkg::ST_DONE;
            n_rv   = w_rd_val;
            n_rc   = '0;
            n_used = w_used_m1;
        end

        if (i_cmd.srch) begin
            priority if (w_hit) begin
                n_pos   = r_di;
                n_found = (w_rd_val == r_val);
                n_cnt   = w_rd_cnt;
                n_dv    = 1'b0;
            end else if (w_exhaust) begin
                n_pos   = r_ra;
                n_found = 1'b0;
            end else begin
                // one read in flight per cycle
                n_dv = (r_ra < r_used);
                n_di = r_ra;
                if (r_ra < r_used) begin
                    n_ra = r_ra + UW'(1);
                end
            end
        end

        if (i_cmd.decide) begin
            n_rv = r_val;
            n_dv = 1'b0;
            if (r_req == smt_pkg::REQ_INSERT) begin
                priority if (r_found) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos[IW-1:0];
                    w_wdata = {r_val, w_cnt_inc};
                    n_st    = smt_pkg::ST_DONE;
                    n_rc    = w_cnt_inc;
                end else if (w_full) begin
                    n_st = smt_pkg::ST_FULL;
                    n_rc = '0;
                end else begin
                    n_st  = smt_pkg::ST_DONE;
                    n_rc  = CW'(1);
                    n_up  = 1'b0;
                    n_ra  = w_used_m1;
                    n_rem = r_used - r_pos;
                end
            end else begin
                priority if (!r_found) begin
                    n_st = smt_pkg::ST_NOT_FOUND;
                    n_rc = '0;
                end else if (r_cnt > CW'(1)) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos[IW-1:0];
                    w_wdata = {r_val, r_cnt - CW'(1)};
                    n_st    = smt_pkg::ST_DONE;
                    n_rc    = r_cnt - CW'(1);
                end else begin
                    n_st  = smt_pkg::ST_DONE;
                    n_rc  = '0;
                    n_up  = 1'b1;
                    n_ra  = r_pos + UW'(1);
                    n_rem = w_used_m1 - r_pos;
                end
            end
        end

        if (i_cmd.shift) begin
            if (r_dv) begin
                w_we    = 1'b1;
                w_waddr = w_sh_addr[IW-1:0];
                w_wdata = w_rdata;
            end
            if (r_rem != '0) begin
                n_dv  = 1'b1;
                n_di  = r_ra;
                n_ra  = r_up ? (r_ra + UW'(1)) : (r_ra - UW'(1));
                n_rem = r_rem - UW'(1);
            end else begin
                n_dv = 1'b0;
            end
            if (o_sts.shift_done) begin
                if (r_up) begin
                    n_used = w_used_m1;
                end else begin
                    // gap is open, drop the new entry in
                    w_we    = 1'b1;
                    w_waddr = r_pos[IW-1:0];
                    w_wdata = {r_val, CW'(1)};
                    n_used  = r_used + UW'(1);
                end
            end
        end

        if (i_cmd.out_load) begin
            n_ovalid = 1'b1;
            n_ost    = r_st;
            n_orv    = r_rv;
            n_orc    = r_rc;
            n_oused  = r_used;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_ovalid <= 1'b0;
            r_dv     <= 1'b0;
            r_rem    <= '0;
        end else begin
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
            r_dv     <= n_dv;
            r_rem    <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_val   <= n_val;
        r_ra    <= n_ra;
        r_di    <= n_di;
        r_up    <= n_up;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_cnt   <= n_cnt;
        r_st    <= n_st;
        r_rv    <= n_rv;
        r_rc    <= n_rc;
        r_ost   <= n_ost;
        r_orv   <= n_orv;
        r_orc   <= n_orc;
        r_oused <= n_oused;
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_ost;
    assign o_result_value = r_orv;
    assign o_value_count  = smt_pkg::CNT_OUT_W'(r_orc);
    assign o_entries_used = smt_pkg::USED_OUT_W'(r_oused);

endmodule

`default_nettype wire

// File: rtl/sorted_multiset_table.sv
// ----------------------------------------------------------------------------
// sorted_multiset_table
// Table of distinct signed values kept in ascending order, each with a
// saturating occurrence count; insert, delete, remove-max and clear.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per transaction (req_type, value); o_rsp
//   returns exactly one result per request (status, result_value,
//   value_count, entries_used). Both use valid/ready.
//   One request is processed at a time. Clear, and delete or remove-max on
//   an empty table, finish at dispatch; remove-max reads the last entry;
//   insert and delete search from the head for the sorted position pos,
//   then shift the entries behind pos when an entry is added or removed;
//   most entries move for an insert at the head of a table one short of
//   full or a delete at the head of a full one. The entry memory has one
//   read and one write port, so search and shift each handle one entry
//   per cycle. A new request is taken the cycle after its result is placed
//   in the output register, even while that result is still held there.
//   Reset empties the table (entry storage itself is not cleared) and drops
//   any pending result. When the receiver stalls, the result holds on o_rsp
//   and the block finishes its next request, then waits in its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_multiset_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    smt_req_if.sink    i_req,
    smt_rsp_if.source  o_rsp
);

    smt_pkg::t_dp_cmd w_cmd;
    smt_pkg::t_dp_sts w_sts;
    logic             w_in_ready;

    smt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    smt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_req_type     (i_req.req_type),
        .i_value        (i_req.value),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_result_value (o_rsp.result_value),
        .o_value_count  (o_rsp.value_count),
        .o_entries_used (o_rsp.entries_used)
    );

    assign i_req.ready = w_in_ready;

`ifndef ASSERT_OFF
    // a result never follows its request in the very next cycle
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !w_cmd.out_load)
        else $error("result loaded one cycle after request");

    // the table never reports more entries than it holds
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.entries_used <= smt_pkg::USED_OUT_W'(smt_pkg::CAPACITY)))
        else $error("entries_used above capacity");

    // a dropped insert only happens on a full table and carries no count
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == smt_pkg::ST_FULL)) |->
        ((o_rsp.value_count == '0) &&
         (o_rsp.entries_used == smt_pkg::USED_OUT_W'(smt_pkg::CAPACITY))))
        else $error("full status with inconsistent fields");

    // no new request is taken while a result is being loaded
    a_busy_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !w_in_ready)
        else $error("request accepted during result load");
`endif

endmodule

`default_nettype wire
